FILE: src/masked_window_mean_filter_macros.svh
// ----------------------------------------------------------------------------
// Masked window mean filter assertion macros
// Shared assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MASKED_WINDOW_MEAN_FILTER_MACROS_SVH
`define MASKED_WINDOW_MEAN_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define MWMF_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mwmf assertion failed");
`define MWMF_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mwmf assertion failed");
`else
`define MWMF_ASSERT_IMP(label, clk, rst_n, pre, post)
`define MWMF_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

FILE: src/mwmf_pkg.sv
// ----------------------------------------------------------------------------
// Masked window mean filter package
// Sequencer states, register indexes, method codes and output limits.
// ----------------------------------------------------------------------------
`default_nettype none

package mwmf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_GATHER,
    ST_FLUSH,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } mwmf_state_t;

  localparam int OUT_BITS      = 22;
  localparam int ROW_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_W_BITS    = 12;
  localparam int CFG_R_BITS    = 3;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 22'sd1048575;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = -22'sd1048576;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SHAPE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_METHOD       = 3'd4;

  localparam logic [1:0] METHOD_SMOOTH  = 2'd0;
  localparam logic [1:0] METHOD_SHARPEN = 2'd1;
  localparam logic [1:0] METHOD_EDGE    = 2'd2;

  localparam logic SHAPE_SQUARE = 1'b0;
  localparam logic SHAPE_CIRCLE = 1'b1;

endpackage

`default_nettype wire

FILE: src/mwmf_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step; a chain of these forms the quotient bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mwmf_div_cell #(
  parameter int NW   = 27,
  parameter int DENW = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_num,
  input  logic [DENW-1:0] in_rem,
  input  logic [NW-1:0]   in_quo,
  input  logic [DENW-1:0] in_den,
  output logic            out_valid,
  output logic [NW-1:0]   out_num,
  output logic [DENW-1:0] out_rem,
  output logic [NW-1:0]   out_quo,
  output logic [DENW-1:0] out_den
);

  logic [DENW:0] trial;
  logic          ge;
  logic [DENW:0] diff;
  logic          valid_r;
  logic [NW-1:0] num_r;
  logic [DENW-1:0] rem_r;
  logic [NW-1:0] quo_r;
  logic [DENW-1:0] den_r;

  assign trial = {in_rem, in_num[NW-1]};
  assign ge    = trial >= {1'b0, in_den};
  assign diff  = trial - {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= {in_num[NW-2:0], 1'b0};
    rem_r <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
    quo_r <= {in_quo[NW-2:0], ge};
    den_r <= in_den;
  end

  assign out_valid = valid_r;
  assign out_num   = num_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_den   = den_r;

endmodule

`default_nettype wire

FILE: src/masked_window_mean_filter.sv
// An item that yields no result goes from idle through the decide state back to idle.
// An item that yields a result has its window scanned through the single read port of
// the line store, then the mean passes the divider cell chain.
// One item is in work at a time.
// Reset is synchronous and clears control and counters; the line store is not cleared.
// ----------------------------------------------------------------------------
// Masked window mean filter
// Line store, window scan sequencer and divider chain for masked window means.
// ----------------------------------------------------------------------------
`default_nettype none
`include "masked_window_mean_filter_macros.svh"

module masked_window_mean_filter #(
  parameter int MAX_RADIUS  = 4,
  parameter int MAX_WIDTH   = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  logic                                   in_sample_is_nodata,
  input  logic                                   in_drain,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mwmf_pkg::OUT_BITS-1:0]   out_filtered,
  output logic                                   out_result_is_nodata,
  output logic                                   out_last_of_frame,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mwmf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mwmf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  import mwmf_pkg::*;

  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int SLW  = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RB   = $clog2(MAX_RADIUS + 1);
  localparam int DXW  = RB + 1;
  localparam int NPOS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NCW  = $clog2(NPOS + 1);
  localparam int SW   = SAMPLE_BITS + NCW;
  localparam int DW   = SW + 4;
  localparam int EW   = SAMPLE_BITS + 1;
  localparam int AW   = $clog2(RING * MAX_WIDTH);
  localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int XW   = CW + 2;
  localparam int YW   = ROW_BITS + 2;
  localparam int STW  = SLW + 2;
  localparam int QW   = 2 * DXW + 1;
  localparam int RW   = (DW + 2 > OUT_BITS) ? DW + 2 : OUT_BITS + 1;

  mwmf_state_t state_r, state_nxt;

  logic [CFG_W_BITS-1:0] cfg_w_r;
  logic [ROW_BITS-1:0]   cfg_h_r;
  logic [CFG_R_BITS-1:0] cfg_rad_r;
  logic                  cfg_shape_r;
  logic [1:0]            cfg_method_r;

  logic [WW-1:0]       cur_w_r;
  logic [ROW_BITS-1:0] cur_h_r;
  logic [RB-1:0]       cur_r_r;
  logic                cur_shape_r;
  logic [1:0]          cur_method_r;
  logic                frame_open_r;

  logic [CW-1:0]       in_col_r;
  logic [ROW_BITS-1:0] in_row_r;
  logic [SLW-1:0]      in_slot_r;
  logic [CW-1:0]       out_col_r;
  logic [ROW_BITS-1:0] out_row_r;
  logic [SLW-1:0]      out_slot_r;
  logic [LW-1:0]       lag_r;

  logic signed [DXW-1:0] dx_r, dy_r;
  logic                  use_r, center_r;
  logic [EW-1:0]         rd_data_r;
  logic signed [SW-1:0]  sum_r;
  logic [NCW-1:0]        cnt_r;
  logic signed [SAMPLE_BITS-1:0] cval_r;
  logic                  cok_r;

  logic [EW-1:0] line_store_r [RING * MAX_WIDTH];

  logic                          out_valid_r;
  logic signed [OUT_BITS-1:0]    out_filtered_r;
  logic                          out_nodata_r;
  logic                          out_last_r;

  logic                  in_acc, is_samp, wr_en, ch_in_valid, out_free, emit;
  logic [WW-1:0]         lat_w, eff_w;
  logic [ROW_BITS-1:0]   lat_h;
  logic [RB-1:0]         lat_r;
  logic [1:0]            lat_method;
  logic [LW-1:0]         thr;
  logic                  due, last_pos, pos_ok, win_ok, last_px;
  logic signed [DXW-1:0] r_s;
  logic signed [QW-1:0]  dxq, dyq, rq;
  logic signed [XW-1:0]  x_s;
  logic signed [YW-1:0]  y_s;
  logic signed [STW-1:0] s_raw, s_adj;
  logic [SLW-1:0]        rd_slot;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_val;
  logic [SW-1:0]         mag;
  logic [NCW-1:0]        den;
  logic [DW-1:0]         num;
  logic signed [RW-1:0]  mean_s, val_s, res_s;
  logic signed [OUT_BITS-1:0] res_sat;

  logic          ch_valid [DW+1];
  logic [DW-1:0] ch_num   [DW+1];
  logic [NCW-1:0] ch_rem  [DW+1];
  logic [DW-1:0] ch_quo   [DW+1];
  logic [NCW-1:0] ch_den  [DW+1];

  // Registers are taken over when the first sample of a frame is transferred.
  always_comb begin
    if (cfg_w_r == '0) begin
      lat_w = WW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      lat_w = WW'(MAX_WIDTH);
    end else begin
      lat_w = WW'(cfg_w_r);
    end
    lat_h = (cfg_h_r == '0) ? ROW_BITS'(1) : cfg_h_r;
    if (cfg_rad_r == '0) begin
      lat_r = RB'(1);
    end else if (32'(cfg_rad_r) > MAX_RADIUS) begin
      lat_r = RB'(MAX_RADIUS);
    end else begin
      lat_r = RB'(cfg_rad_r);
    end
    lat_method = (cfg_method_r > METHOD_EDGE) ? METHOD_SMOOTH : cfg_method_r;
    eff_w = frame_open_r ? cur_w_r : lat_w;
  end

  assign in_acc   = in_valid && !in_stall;
  assign is_samp  = !in_drain && !(frame_open_r && in_row_r >= cur_h_r);
  assign thr      = LW'(cur_r_r) * LW'(cur_w_r) + LW'(cur_r_r) + LW'(1);
  assign due      = frame_open_r && (in_row_r >= cur_h_r || lag_r >= thr);
  assign r_s      = $signed(DXW'(cur_r_r));
  assign last_pos = (dx_r == r_s) && (dy_r == r_s);
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (state_r == ST_EMIT) && out_free;
  assign last_px  = ((17'(out_row_r) + 17'd1) >= 17'(cur_h_r))
                 && ((WW'(out_col_r) + WW'(1)) >= cur_w_r);

  always_comb begin
    dxq    = QW'(dx_r);
    dyq    = QW'(dy_r);
    rq     = $signed(QW'(cur_r_r));
    win_ok = (cur_shape_r == SHAPE_SQUARE) || (dxq * dxq + dyq * dyq <= rq * rq);
    x_s    = $signed(XW'(out_col_r)) + XW'(dx_r);
    y_s    = $signed(YW'(out_row_r)) + YW'(dy_r);
    pos_ok = win_ok && (x_s >= 0) && (x_s < $signed(XW'(cur_w_r)))
          && (y_s >= 0) && (y_s < $signed(YW'(cur_h_r)));
    s_raw  = $signed(STW'(out_slot_r)) + STW'(dy_r);
    if (s_raw < 0) begin
      s_adj = s_raw + STW'(RING);
    end else if (s_raw >= $signed(STW'(RING))) begin
      s_adj = s_raw - STW'(RING);
    end else begin
      s_adj = s_raw;
    end
    rd_slot = SLW'(s_adj);
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(x_s[CW-1:0]);
    wr_addr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = due ? ST_GATHER : ST_IDLE;
      ST_GATHER: if (last_pos) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_WAIT;
      ST_WAIT:   if (ch_valid[DW]) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    cfg_ready   = 1'b1;
    wr_en       = in_acc && is_samp;
    ch_in_valid = (state_r == ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r      <= CFG_W_BITS'(2048);
      cfg_h_r      <= ROW_BITS'(1);
      cfg_rad_r    <= CFG_R_BITS'(1);
      cfg_shape_r  <= SHAPE_CIRCLE;
      cfg_method_r <= METHOD_SMOOTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_w_r      <= cfg_data[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: cfg_h_r      <= cfg_data[ROW_BITS-1:0];
        REG_RADIUS:       cfg_rad_r    <= cfg_data[CFG_R_BITS-1:0];
        REG_WINDOW_SHAPE: cfg_shape_r  <= cfg_data[0];
        REG_METHOD:       cfg_method_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_w_r      <= WW'(MAX_WIDTH);
      cur_h_r      <= ROW_BITS'(1);
      cur_r_r      <= RB'(1);
      cur_shape_r  <= SHAPE_CIRCLE;
      cur_method_r <= METHOD_SMOOTH;
      frame_open_r <= 1'b0;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_slot_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_slot_r   <= '0;
      lag_r        <= '0;
    end else if (wr_en) begin
      if (!frame_open_r) begin
        cur_w_r      <= lat_w;
        cur_h_r      <= lat_h;
        cur_r_r      <= lat_r;
        cur_shape_r  <= cfg_shape_r;
        cur_method_r <= lat_method;
        frame_open_r <= 1'b1;
      end
      lag_r <= lag_r + LW'(1);
      if ((WW'(in_col_r) + WW'(1)) >= eff_w) begin
        in_col_r  <= '0;
        in_row_r  <= in_row_r + ROW_BITS'(1);
        in_slot_r <= (in_slot_r == SLW'(RING - 1)) ? '0 : in_slot_r + SLW'(1);
      end else begin
        in_col_r <= in_col_r + CW'(1);
      end
    end else if (emit) begin
      if (last_px) begin
        frame_open_r <= 1'b0;
        in_col_r     <= '0;
        in_row_r     <= '0;
        in_slot_r    <= '0;
        out_col_r    <= '0;
        out_row_r    <= '0;
        out_slot_r   <= '0;
        lag_r        <= '0;
      end else begin
        lag_r <= lag_r - LW'(1);
        if ((WW'(out_col_r) + WW'(1)) >= cur_w_r) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + ROW_BITS'(1);
          out_slot_r <= (out_slot_r == SLW'(RING - 1)) ? '0 : out_slot_r + SLW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store_r[wr_addr] <= {!in_sample_is_nodata, in_sample};
    end
    rd_data_r <= line_store_r[rd_addr];
  end

  assign rd_val = $signed(rd_data_r[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r    <= 1'b0;
      center_r <= 1'b0;
    end else begin
      use_r    <= (state_r == ST_GATHER) && pos_ok;
      center_r <= (state_r == ST_GATHER) && (dx_r == '0) && (dy_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      dx_r  <= -r_s;
      dy_r  <= -r_s;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (state_r == ST_GATHER) begin
        if (dx_r == r_s) begin
          dx_r <= -r_s;
          dy_r <= dy_r + DXW'(1);
        end else begin
          dx_r <= dx_r + DXW'(1);
        end
      end
      if (use_r && rd_data_r[EW-1]) begin
        sum_r <= sum_r + SW'(rd_val);
        cnt_r <= cnt_r + NCW'(1);
      end
    end
    if (center_r) begin
      cval_r <= rd_val;
      cok_r  <= rd_data_r[EW-1];
    end
  end

  assign mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign den = (cnt_r == '0) ? NCW'(1) : cnt_r;
  assign num = {mag, 4'b0000} + DW'(cnt_r >> 1);

  assign ch_valid[0] = ch_in_valid;
  assign ch_num[0]   = num;
  assign ch_rem[0]   = '0;
  assign ch_quo[0]   = '0;
  assign ch_den[0]   = den;

  for (genvar i = 0; i < DW; i++) begin : g_div
    mwmf_div_cell #(
      .NW   (DW),
      .DENW (NCW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[i]),
      .in_num    (ch_num[i]),
      .in_rem    (ch_rem[i]),
      .in_quo    (ch_quo[i]),
      .in_den    (ch_den[i]),
      .out_valid (ch_valid[i+1]),
      .out_num   (ch_num[i+1]),
      .out_rem   (ch_rem[i+1]),
      .out_quo   (ch_quo[i+1]),
      .out_den   (ch_den[i+1])
    );
  end

  always_comb begin
    mean_s = sum_r[SW-1] ? -$signed(RW'(ch_quo[DW])) : $signed(RW'(ch_quo[DW]));
    val_s  = RW'(cval_r);
    if (cur_method_r == METHOD_SHARPEN) begin
      res_s = (val_s <<< 5) - mean_s;
    end else if (cur_method_r == METHOD_EDGE) begin
      res_s = (val_s <<< 4) - mean_s;
    end else begin
      res_s = mean_s;
    end
    if (res_s > RW'(OUT_MAX)) begin
      res_sat = OUT_MAX;
    end else if (res_s < RW'(OUT_MIN)) begin
      res_sat = OUT_MIN;
    end else begin
      res_sat = res_s[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_filtered_r <= cok_r ? res_sat : '0;
      out_nodata_r   <= !cok_r;
      out_last_r     <= last_px;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_filtered         = out_filtered_r;
  assign out_result_is_nodata = out_nodata_r;
  assign out_last_of_frame    = out_last_r;

  `MWMF_ASSERT_IMP(a_div_only_waiting, clk, rst_n, ch_valid[DW], state_r == ST_WAIT)
  `MWMF_ASSERT_IMP(a_lag_bounded, clk, rst_n, frame_open_r, lag_r <= thr)
  `MWMF_ASSERT_NXT(a_frame_close, clk, rst_n, emit && last_px, !frame_open_r && lag_r == '0)

endmodule

`default_nettype wire
